// ===== src/hlmc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlmc_pkg
// Shared types and constants of the hot line migration controller: the
// controller state encoding, the command and status groups between the
// controller and the datapath, and the counter and register constants.
// ----------------------------------------------------------------------------
package hlmc_pkg;

  // Saturating access counter held in each remap entry
  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] CntMax = 7'd127;

  // Promotion threshold register
  localparam int unsigned ThreshW = 7;
  localparam logic [ThreshW-1:0] ThreshReset = 7'd16;

  // Command index within one access: up to four commands
  localparam int unsigned CmdIdxW = 2;

  // Issue time
  localparam int unsigned TimeW = 32;
  localparam logic [TimeW-1:0] TimeMax = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_CLEAR,   // sweep the remap table after reset
    ST_IDLE,    // wait for an access word
    ST_LOOKUP,  // entry read back, decide and write back
    ST_EMIT     // issue commands, one per cycle while the output register is free
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic               clr_en;
    logic               load;
    logic               decide;
    logic               emit;
    logic [CmdIdxW-1:0] idx;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic out_free;
    logic last_cmd;
  } dp_status_t;

endpackage

// ===== src/hlmc_dpath.sv =====
// ----------------------------------------------------------------------------
// hlmc_dpath
// Datapath: remap table memory, access registers, counter update and
// migration decision, issue time tracking, command generation and the
// output register.
// ----------------------------------------------------------------------------
module hlmc_dpath #(
  parameter int unsigned LINE_OFFSET_BITS   = 6,
  parameter int unsigned REMAP_INDEX_BITS   = 10,
  parameter int unsigned SEGMENT_INDEX_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hlmc_pkg::ctrl_cmd_t   cmd_i,
  output hlmc_pkg::dp_status_t  status_o,
  input  logic [31:0]           address_i,
  input  logic                  is_write_i,
  input  logic [31:0]           time_stamp_i,
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  to_fast_o,
  output logic [31:0]           out_address_o,
  output logic                  out_write_o,
  output logic [31:0]           out_time_o,
  output logic                  last_o
);
  import hlmc_pkg::*;

  localparam int unsigned Depth    = 1 << REMAP_INDEX_BITS;
  localparam int unsigned SegShift = LINE_OFFSET_BITS + REMAP_INDEX_BITS;
  localparam int unsigned EntryW   = 1 + SEGMENT_INDEX_BITS + CntW;

  // Remap table: {valid, resident segment, counter}
  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rd_q;
  logic [EntryW-1:0] wr_data;
  logic [REMAP_INDEX_BITS-1:0] wr_addr;
  logic              wr_en;

  logic [REMAP_INDEX_BITS-1:0] clr_cnt_q;
  logic [ThreshW-1:0]          thresh_q;

  // Access registers
  logic [31:0]                 addr_q;
  logic                        wr_q;
  logic [TimeW-1:0]            t_q;
  logic [TimeW-1:0]            issue_time_q;
  logic [TimeW-1:0]            issue_time_d;
  logic [REMAP_INDEX_BITS-1:0] ri_q;

  // Decision registers
  logic                          hit_q;
  logic                          mig_q;
  logic                          val_q;
  logic [SEGMENT_INDEX_BITS-1:0] res_q;

  // Decode of the read entry
  logic                          ent_valid;
  logic [SEGMENT_INDEX_BITS-1:0] ent_res;
  logic [CntW-1:0]               ent_cnt;
  logic [CntW-1:0]               cnt_new;
  logic [SEGMENT_INDEX_BITS-1:0] seg;
  logic [63:0]                   addr_ext;
  logic                          hit;
  logic                          mig;

  logic [TimeW-1:0] t1;
  logic [TimeW-1:0] t2;
  logic [31:0]      slot;
  logic [63:0]      evict_wide;
  logic [31:0]      evict;
  logic [CmdIdxW-1:0] last_idx;
  logic [CmdIdxW-1:0] pos;

  logic        cmd_fast;
  logic [31:0] cmd_addr;
  logic        cmd_write;
  logic [TimeW-1:0] cmd_time;

  // Output register
  logic             out_valid_q;
  logic             fast_q;
  logic [31:0]      oaddr_q;
  logic             owr_q;
  logic [TimeW-1:0] otime_q;
  logic             olast_q;

  // Field extraction
  assign addr_ext  = {32'b0, addr_q};
  assign seg       = addr_ext[SegShift +: SEGMENT_INDEX_BITS];
  assign ent_valid = rd_q[EntryW-1];
  assign ent_res   = rd_q[CntW +: SEGMENT_INDEX_BITS];
  assign ent_cnt   = rd_q[CntW-1:0];
  assign slot      = 32'(ri_q) << LINE_OFFSET_BITS;
  assign evict_wide = 64'(res_q) << SegShift;
  assign evict     = evict_wide[31:0] | slot;

  // Counter update and migration decision
  always_comb begin
    hit = ent_valid && (ent_res == seg);
    cnt_new = ent_cnt;
    if (hit) begin
      if (ent_cnt != '0) cnt_new = ent_cnt - 1'b1;
    end else if (ent_cnt != CntMax) begin
      cnt_new = ent_cnt + 1'b1;
    end
    mig = (cnt_new >= thresh_q);
  end

  // Saturating time steps
  assign t1 = (t_q == TimeMax) ? t_q : t_q + 1'b1;
  assign t2 = (t1 == TimeMax) ? t1 : t1 + 1'b1;

  // Issue time after this access: two steps when a migration ends in a
  // second command group, otherwise one
  assign issue_time_d = (mig && (ent_valid || !wr_q)) ? t2 : t1;

  // Table write port: clearing sweep or decision write-back
  always_comb begin
    wr_en   = cmd_i.clr_en || cmd_i.decide;
    wr_addr = cmd_i.clr_en ? clr_cnt_q : ri_q;
    if (cmd_i.clr_en) begin
      wr_data = '0;
    end else if (mig) begin
      wr_data = {1'b1, seg, {CntW{1'b0}}};
    end else begin
      wr_data = {ent_valid, ent_res, cnt_new};
    end
  end

  // Remap table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.load) rd_q <= mem_q[address_i[LINE_OFFSET_BITS +: REMAP_INDEX_BITS]];
  end

  // Clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Issue time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_time_q <= '0;
    end else if (cmd_i.decide) begin
      issue_time_q <= issue_time_d;
    end
  end

  // Access capture; base time is max(issue time, time stamp)
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= address_i;
      wr_q   <= is_write_i;
      ri_q   <= address_i[LINE_OFFSET_BITS +: REMAP_INDEX_BITS];
      t_q    <= (time_stamp_i > issue_time_q) ? time_stamp_i : issue_time_q;
    end
    if (cmd_i.decide) begin
      hit_q <= hit;
      mig_q <= mig;
      val_q <= ent_valid;
      res_q <= ent_res;
    end
  end

  // Index of the final command
  always_comb begin
    if (!mig_q)      last_idx = 2'd0;
    else if (!val_q) last_idx = wr_q ? 2'd0 : 2'd1;
    else             last_idx = wr_q ? 2'd2 : 2'd3;
  end

  // A migrating write skips the slow read that opens the sequence
  assign pos = (mig_q && wr_q) ? cmd_i.idx + 1'b1 : cmd_i.idx;

  // Command generation
  always_comb begin
    cmd_fast  = 1'b0;
    cmd_addr  = addr_q;
    cmd_write = 1'b0;
    cmd_time  = t_q;
    if (!mig_q) begin
      cmd_fast  = hit_q;
      cmd_addr  = hit_q ? slot : addr_q;
      cmd_write = wr_q;
    end else if (!val_q) begin
      // fill
      if (pos != 2'd0) begin
        cmd_fast  = 1'b1;
        cmd_addr  = slot;
        cmd_write = 1'b1;
        cmd_time  = wr_q ? t_q : t1;
      end
    end else begin
      // swap
      case (pos)
        2'd0: begin
          cmd_fast = 1'b0;
          cmd_addr = addr_q;
        end
        2'd1: begin
          cmd_fast = 1'b1;
          cmd_addr = slot;
        end
        2'd2: begin
          cmd_fast  = 1'b0;
          cmd_addr  = evict;
          cmd_write = 1'b1;
          cmd_time  = t1;
        end
        default: begin
          cmd_fast  = 1'b1;
          cmd_addr  = slot;
          cmd_write = 1'b1;
          cmd_time  = t1;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fast_q  <= cmd_fast;
      oaddr_q <= cmd_addr;
      owr_q   <= cmd_write;
      otime_q <= cmd_time;
      olast_q <= (cmd_i.idx == last_idx);
    end
  end

  assign status_o.clr_done = &clr_cnt_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_cmd = (cmd_i.idx == last_idx);

  assign out_valid_o   = out_valid_q;
  assign to_fast_o     = fast_q;
  assign out_address_o = oaddr_q;
  assign out_write_o   = owr_q;
  assign out_time_o    = otime_q;
  assign last_o        = olast_q;

endmodule

// ===== src/hlmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hlmc_ctrl
// Controller: clearing sweep after reset, access intake, decision cycle and
// command sequencing into the output register.
// ----------------------------------------------------------------------------
module hlmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hlmc_pkg::dp_status_t status_i,
  output hlmc_pkg::ctrl_cmd_t  cmd_o
);
  import hlmc_pkg::*;

  state_e             state_q, state_d;
  logic [CmdIdxW-1:0] idx_q, idx_d;

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_EMIT;
        idx_d   = '0;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          if (status_i.last_cmd) begin
            state_d = ST_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.clr_en = (state_q == ST_CLEAR);
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.decide = (state_q == ST_LOOKUP);
    cmd_o.emit   = (state_q == ST_EMIT) && status_i.out_free;
    cmd_o.idx    = idx_q;
    in_ready_o   = (state_q == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted word always goes straight to the decision cycle
  a_load_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_LOOKUP)
    else $error("accepted word did not enter lookup");

  // The decision cycle always hands over to command issue at index zero
  a_lookup_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |=> (state_q == ST_EMIT) && (idx_q == '0))
    else $error("lookup not followed by emit");

  // Issuing the final command returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && status_i.last_cmd) |=> state_q == ST_IDLE)
    else $error("final command did not end the sequence");

  // The command index is at rest outside of command issue
  a_idx_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> idx_q == '0)
    else $error("command index not cleared");
`endif

endmodule

// ===== src/hot_line_migration_controller_unit.sv =====
// ----------------------------------------------------------------------------
// hot_line_migration_controller_unit
// Counter-based line migration for a hybrid fast/slow memory: routes each
// access word, or turns a hot line into a fill or swap command sequence.
// ----------------------------------------------------------------------------
// After reset the block sweeps its remap table, one entry per cycle, over all
// 2**REMAP_INDEX_BITS entries (1024 by default) and takes no access word until
// the sweep ends; the threshold register can be written meanwhile. Each access
// then causes n memory commands (1 to 4): the block accepts the word and reads
// the table memory, then decides and writes the entry back, then loads the
// commands into the output register, one per cycle while that register is
// free. A plain access causes one command, a full swap four. Commands come out in
// order with last set on the final one; the next word is accepted while that
// final command still waits in the output register.
// ----------------------------------------------------------------------------
module hot_line_migration_controller_unit #(
  parameter int unsigned LINE_OFFSET_BITS   = 6,
  parameter int unsigned REMAP_INDEX_BITS   = 10,
  parameter int unsigned SEGMENT_INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] address_i,
  input  logic        is_write_i,
  input  logic [31:0] time_stamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        to_fast_o,
  output logic [31:0] out_address_o,
  output logic        out_write_o,
  output logic [31:0] out_time_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import hlmc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hlmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hlmc_dpath #(
    .LINE_OFFSET_BITS   (LINE_OFFSET_BITS),
    .REMAP_INDEX_BITS   (REMAP_INDEX_BITS),
    .SEGMENT_INDEX_BITS (SEGMENT_INDEX_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .address_i     (address_i),
    .is_write_i    (is_write_i),
    .time_stamp_i  (time_stamp_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .to_fast_o     (to_fast_o),
    .out_address_o (out_address_o),
    .out_write_o   (out_write_o),
    .out_time_o    (out_time_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hot line migration controller. A scoreboard
// class tracks the remap table, the issue time and the threshold, predicts
// the memory commands of every accepted access word and checks each command
// word in order. Directed words cover the fill, swap and routing paths; then
// random phases step through several thresholds, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlmc_pkg::*;

  localparam int unsigned OffBits    = 6;
  localparam int unsigned IdxBits    = 10;
  localparam int unsigned SegBits    = 16;
  localparam int unsigned Depth      = 1 << IdxBits;
  localparam int unsigned CycleLimit = 300000;

  // One memory command word
  typedef struct packed {
    logic        to_fast;
    logic [31:0] addr;
    logic        wr;
    logic [31:0] at;
    logic        last;
  } mem_cmd_t;

  // Scoreboard: remap table copy, predicted commands, mismatch count
  class migration_scoreboard;
    logic                 line_valid [Depth];
    logic [SegBits-1:0]   line_seg   [Depth];
    logic [CntW-1:0]      line_count [Depth];
    logic [TimeW-1:0]     issue_time;
    logic [ThreshW-1:0]   threshold;
    mem_cmd_t             expected_cmds [$];
    mem_cmd_t             burst [$];
    int                   errors;

    function new();
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_seg[i]   = '0;
        line_count[i] = '0;
      end
      issue_time = '0;
      threshold  = ThreshReset;
      errors     = 0;
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    // queue one command at the current issue time
    function void stage(logic fast, logic [31:0] a, logic w);
      mem_cmd_t c;
      c.to_fast = fast;
      c.addr    = a;
      c.wr      = w;
      c.at      = issue_time;
      c.last    = 1'b0;
      burst = {burst, c};
    endfunction

    function void advance();
      if (issue_time != TimeMax) issue_time = issue_time + 1;
    endfunction

    // predict the command words of one accepted access
    function void note_access(logic [31:0] a, logic w, logic [31:0] ts);
      logic [IdxBits-1:0] ri;
      logic [SegBits-1:0] seg;
      logic [31:0]        slot;
      logic [31:0]        evict;
      logic               hit;
      ri   = a[OffBits +: IdxBits];
      seg  = a[OffBits+IdxBits +: SegBits];
      slot = 32'(ri) << OffBits;
      hit  = line_valid[ri] && (line_seg[ri] == seg);
      burst.delete();
      if (ts > issue_time) issue_time = ts;

      // saturating hit/miss counter
      if (hit) begin
        if (line_count[ri] != '0) line_count[ri] = line_count[ri] - 1'b1;
      end else if (line_count[ri] != CntMax) begin
        line_count[ri] = line_count[ri] + 1'b1;
      end

      if (line_count[ri] >= threshold) begin
        if (!line_valid[ri]) begin
          // fill
          if (!w) begin
            stage(1'b0, a, 1'b0);
            advance();
          end
          stage(1'b1, slot, 1'b1);
          advance();
        end else begin
          // swap with the resident line
          evict = (32'(line_seg[ri]) << (OffBits + IdxBits)) | slot;
          if (!w) stage(1'b0, a, 1'b0);
          stage(1'b1, slot, 1'b0);
          advance();
          stage(1'b0, evict, 1'b1);
          stage(1'b1, slot, 1'b1);
          advance();
        end
        line_valid[ri] = 1'b1;
        line_seg[ri]   = seg;
        line_count[ri] = '0;
      end else begin
        stage(hit, hit ? slot : a, w);
        advance();
      end

      burst[burst.size()-1].last = 1'b1;
      expected_cmds = {expected_cmds, burst};
    endfunction

    // compare one accepted command word with the oldest prediction
    function void check_command(mem_cmd_t got);
      mem_cmd_t want;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected command: fast=%0b addr=%h wr=%0b t=%h last=%0b",
                   got.to_fast, got.addr, got.wr, got.at, got.last);
        return;
      end
      want = expected_cmds.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display({"command mismatch: exp fast=%0b addr=%h wr=%0b t=%h last=%0b",
                    " | act fast=%0b addr=%h wr=%0b t=%h last=%0b"},
                   want.to_fast, want.addr, want.wr, want.at, want.last,
                   got.to_fast, got.addr, got.wr, got.at, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] address = '0;
  logic        is_write = 1'b0;
  logic [31:0] time_stamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        to_fast;
  logic [31:0] out_address;
  logic        out_write;
  logic [31:0] out_time;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  migration_scoreboard sb = new();
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;

  hot_line_migration_controller_unit #(
    .LINE_OFFSET_BITS  (OffBits),
    .REMAP_INDEX_BITS  (IdxBits),
    .SEGMENT_INDEX_BITS(SegBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .address_i    (address),
    .is_write_i   (is_write),
    .time_stamp_i (time_stamp),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .to_fast_o    (to_fast),
    .out_address_o(out_address),
    .out_write_o  (out_write),
    .out_time_o   (out_time),
    .last_o       (last),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("hot_line_migration_controller_unit regression: fail");
      $finish;
    end
  end

  // command monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_command('{to_fast, out_address, out_write, out_time, last});
  end

  // command receiver with random stalls
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready = 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // send one access word; entered and left at a falling edge
  task automatic send_access(input logic [31:0] a, input logic w, input logic [31:0] ts);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   = 1'b1;
    address    = a;
    is_write   = w;
    time_stamp = ts;
    do @(posedge clk_i); while (!in_ready);
    sb.note_access(a, w, ts);
    @(negedge clk_i);
  endtask

  // stop sending and wait for every predicted command
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic set_threshold(input logic [6:0] v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.threshold = v;
  endtask

  initial begin
    logic [IdxBits-1:0] idx_pool [4];
    logic [SegBits-1:0] seg_pool [3];
    logic [31:0]        a;
    logic [31:0]        tbase;
    logic [31:0]        ts;
    logic [6:0]         thr;
    int                 npool;
    int                 nitems;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // default threshold: plain misses, field extremes, stale time stamp
    send_access(32'h0000_0000, 1'b0, 32'h0000_0000);
    send_access(32'hFFFF_FFFF, 1'b1, 32'h0000_0003);
    send_access(32'h0000_0040, 1'b1, 32'h0000_0000);
    wait_idle();

    // threshold zero: fills, swaps on hits, swaps on misses
    set_threshold(7'd0);
    send_access(32'h0001_0080, 1'b0, 32'd10);
    send_access(32'h0002_00C0, 1'b1, 32'd11);
    send_access(32'h0001_0080, 1'b0, 32'd12);
    send_access(32'h0002_00C0, 1'b1, 32'd12);
    send_access(32'h0005_0080, 1'b0, 32'd40);
    send_access(32'h0007_00C0, 1'b1, 32'd40);
    wait_idle();

    // threshold two: counting, routed hits, fill and swap
    set_threshold(7'd2);
    send_access(32'h0003_0100, 1'b0, 32'd50);
    send_access(32'h0003_0100, 1'b1, 32'd50);
    send_access(32'h0003_0110, 1'b0, 32'd51);
    send_access(32'h0003_0120, 1'b1, 32'd51);
    send_access(32'h0009_0100, 1'b0, 32'd52);
    send_access(32'h0003_0100, 1'b0, 32'd52);
    send_access(32'h0009_0100, 1'b1, 32'd53);
    send_access(32'h0009_0104, 1'b0, 32'd53);
    wait_idle();

    // raise a counter, then drop the threshold under it: swap on a hit
    set_threshold(7'd4);
    send_access(32'h0003_0100, 1'b0, 32'd60);
    send_access(32'h0003_0108, 1'b1, 32'd60);
    send_access(32'h0003_0100, 1'b0, 32'd61);
    wait_idle();
    set_threshold(7'd1);
    send_access(32'h0009_0100, 1'b0, 32'd62);
    wait_idle();

    // random phases, hot lines drawn from small pools
    tbase = 32'd100;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: thr = 7'd3;
        1: thr = 7'd127;
        2: thr = 7'd1;
        3: thr = 7'd0;
        4: thr = 7'($urandom_range(1, 8));
        default: thr = 7'($urandom_range(1, 127));
      endcase
      set_threshold(thr);
      no_idle = ($urandom_range(0, 2) == 0);
      npool   = (thr == 7'd127) ? 1 : 4;
      nitems  = (thr == 7'd127) ? 128 : 15;
      foreach (idx_pool[i]) idx_pool[i] = IdxBits'($urandom);
      foreach (seg_pool[i]) seg_pool[i] = SegBits'($urandom);
      repeat (nitems) begin
        if ($urandom_range(0, 9) == 0) begin
          a = $urandom;
        end else begin
          a = {seg_pool[$urandom_range(0, 2)], idx_pool[$urandom_range(0, npool-1)],
               OffBits'($urandom)};
        end
        if ($urandom_range(0, 3) == 0) ts = $urandom_range(0, tbase);
        else ts = tbase + $urandom_range(0, 12);
        tbase = tbase + $urandom_range(0, 6);
        send_access(a, 1'($urandom), ts);
      end
      wait_idle();
    end

    // issue time saturation
    no_idle = 1'b0;
    set_threshold(7'd16);
    send_access($urandom, 1'b0, 32'hFFFF_FFFE);
    send_access($urandom, 1'b1, 32'hFFFF_FFFF);
    send_access($urandom, 1'b0, 32'd5);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hot_line_migration_controller_unit regression: pass");
    end else begin
      $display("hot_line_migration_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
